// ===== hw/rtl/ple_pkg.sv =====
package ple_pkg;

    // list size and derived widths
    localparam int CAPACITY = 32;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW       = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_INS_FRONT = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FIRST = 3'd3,
        CMD_DEL_LAST  = 3'd4,
        CMD_DEL_POS   = 3'd5,
        CMD_READ_OUT  = 3'd6
    } t_cmd_code;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
        logic [5:0]         position;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] item_value;
        logic [5:0]         entry_count;
        logic               last;
    } t_res;

endpackage

// ===== hw/rtl/ple_cmd_if.sv =====
interface ple_cmd_if;
    import ple_pkg::*;
    logic valid;
    logic ready;
    t_cmd payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ple_res_if.sv =====
interface ple_res_if;
    import ple_pkg::*;
    logic valid;
    logic ready;
    t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/positional_list_engine_unit.sv =====
// channel   | dir | handshake    | payload
// i_cmd     | in  | valid/ready  | command, value, position
// o_res     | out | valid/ready  | status, item_value, entry_count, last
//
// insert/delete: accept, one memory read and one write back per shifted entry,
// a closing read, count update and result; failed or unused commands go from
// accept to the result. read out: accept, then a read and a result per entry,
// paced by the registered memory read. a new item is taken only in idle.
// reset (synchronous, active low) clears the count and the control state;
// the memory is not cleared. a stalled output holds its item and the engine
// waits before loading the next one.
module positional_list_engine_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ple_cmd_if.sink   i_cmd,
    ple_res_if.source o_res
);
    import ple_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SHR, S_SHW, S_FIN, S_DONE, S_RD, S_RDW} t_state;

    t_state         r_state;
    logic [CW-1:0]  r_total;
    logic [AW-1:0]  r_wa;
    logic [AW-1:0]  r_pos;
    logic [CW-1:0]  r_moves;
    logic           r_ins;
    logic [1:0]     r_status;
    logic [31:0]    r_val;
    logic           r_ov;
    t_res           r_out;

    logic [31:0]    r_mem [CAPACITY];
    logic [31:0]    r_rdata;

    logic           w_we, w_re;
    logic [AW-1:0]  w_wadr, w_radr;
    logic [31:0]    w_wdata;
    logic           w_ofree;
    logic           w_load;

    // command decode
    logic [7:0]     w_n, w_p;
    logic           w_isins, w_isdel;
    logic [1:0]     w_st;

    assign w_ofree     = !r_ov || o_res.ready;
    assign w_load      = ((r_state == S_DONE) && w_ofree) || (r_state == S_RDW);
    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ov;
    assign o_res.payload = r_out;

    always_comb begin
        w_n     = 8'(r_total);
        w_p     = 8'(i_cmd.payload.position);
        w_isins = 1'b0;
        w_isdel = 1'b0;
        w_st    = ST_OK;
        case (i_cmd.payload.command)
            CMD_APPEND:    begin w_isins = 1'b1; w_p = w_n;  end
            CMD_INS_FRONT: begin w_isins = 1'b1; w_p = 8'd0; end
            CMD_INS_POS:   w_isins = 1'b1;
            CMD_DEL_FIRST: begin w_isdel = 1'b1; w_p = 8'd0; end
            CMD_DEL_LAST:  begin w_isdel = 1'b1; w_p = w_n - 8'd1; end
            CMD_DEL_POS:   w_isdel = 1'b1;
            default: ;
        endcase
        if (w_isins) begin
            if (w_n >= 8'(CAPACITY)) w_st = ST_FULL;
            else begin
                if (w_n == 8'd0) w_p = 8'd0;
                if (w_p > w_n) w_st = ST_RANGE;
            end
        end
        if (w_isdel) begin
            if (w_n == 8'd0) w_st = ST_EMPTY;
            else if (w_p >= w_n) w_st = ST_RANGE;
        end
    end

    // memory access control
    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_wadr  = r_wa;
        w_radr  = r_wa;
        w_wdata = r_rdata;
        case (r_state)
            S_SHR: begin
                w_re   = 1'b1;
                w_radr = r_ins ? r_wa - AW'(1) : r_wa + AW'(1);
            end
            S_SHW: w_we = 1'b1;
            S_FIN: begin
                w_we    = r_ins;
                w_wadr  = r_pos;
                w_wdata = r_val;
            end
            S_RD:  w_re = w_ofree;
            default: ;
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wadr] <= w_wdata;
        if (w_re) r_rdata <= r_mem[w_radr];
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_load) r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_status <= w_st;
                        r_val    <= i_cmd.payload.value;
                        r_ins    <= w_isins;
                        r_pos    <= AW'(w_p);
                        if (i_cmd.payload.command == CMD_READ_OUT) begin
                            r_wa <= '0;
                            if (r_total == '0) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_RD;
                            end
                        end else if (w_st == ST_OK && (w_isins || w_isdel)) begin
                            r_wa    <= w_isins ? AW'(w_n) : AW'(w_p);
                            r_moves <= w_isins ? CW'(w_n - w_p) : CW'(w_n - w_p - 8'd1);
                            r_state <= S_SHR;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SHR: begin
                    if (r_moves == '0) r_state <= S_FIN;
                    else r_state <= S_SHW;
                end
                S_SHW: begin
                    r_wa    <= r_ins ? r_wa - AW'(1) : r_wa + AW'(1);
                    r_moves <= r_moves - CW'(1);
                    r_state <= S_SHR;
                end
                S_FIN: begin
                    r_total <= r_ins ? r_total + CW'(1) : r_total - CW'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_ofree) begin
                        r_out.status      <= r_status;
                        r_out.item_value  <= '0;
                        r_out.entry_count <= 6'(r_total);
                        r_out.last        <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                S_RD: begin
                    if (w_ofree) r_state <= S_RDW;
                end
                S_RDW: begin
                    r_out.status      <= ST_OK;
                    r_out.item_value  <= r_rdata;
                    r_out.entry_count <= 6'(r_total);
                    r_out.last        <= (CW'(r_wa) == r_total - CW'(1));
                    r_wa              <= r_wa + AW'(1);
                    if (CW'(r_wa) == r_total - CW'(1)) r_state <= S_IDLE;
                    else r_state <= S_RD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // count stays within the list size
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // count moves by at most one per command
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_total != $past(r_total)) |->
            (r_total == $past(r_total) + CW'(1) || r_total == $past(r_total) - CW'(1)))
        else $error("entry count jumped");

    // read out never touches an entry past the count
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) && w_re |-> (CW'(w_radr) < r_total))
        else $error("read past end of list");

    // a failed command leaves the count alone
    a_fail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_cmd.valid && (w_st != ST_OK) |=> $stable(r_total))
        else $error("failed command changed the list");
`endif

endmodule

// ===== tb/ple_list_checker.sv =====
`timescale 1ns / 1ps

module ple_list_checker
    import ple_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cmd_valid,
    input  logic   i_cmd_ready,
    input  t_cmd   i_cmd_item,
    input  logic   i_res_valid,
    input  logic   i_res_ready,
    input  t_res   i_res_item,
    output int     o_fail_count,
    output int     o_pending
);

    // shadow copy of the list
    logic signed [31:0] list_cells[CAPACITY];
    int                 list_len;
    t_res               awaited_q[$];

    assign o_pending = awaited_q.size();

    function automatic t_res make_res(t_status st, logic signed [31:0] v, logic fin);
        t_res r;
        r.status      = st;
        r.item_value  = v;
        r.entry_count = 6'(list_len);
        r.last        = fin;
        return r;
    endfunction

    function automatic t_status insert_entry(int pos, logic signed [31:0] v);
        if (list_len >= CAPACITY) return ST_FULL;
        if (list_len == 0) pos = 0;
        if (pos > list_len) return ST_RANGE;
        for (int i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
        list_cells[pos] = v;
        list_len++;
        return ST_OK;
    endfunction

    function automatic t_status remove_entry(int pos);
        if (list_len == 0) return ST_EMPTY;
        if (pos >= list_len) return ST_RANGE;
        for (int i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
        list_len--;
        return ST_OK;
    endfunction

    // work out the result items of one command
    task automatic predict_list_op(t_cmd c);
        t_status st;
        st = ST_OK;
        case (c.command)
            CMD_APPEND:    st = insert_entry(list_len, c.value);
            CMD_INS_FRONT: st = insert_entry(0, c.value);
            CMD_INS_POS:   st = insert_entry(int'(c.position), c.value);
            CMD_DEL_FIRST: st = remove_entry(0);
            CMD_DEL_LAST:  st = (list_len != 0) ? remove_entry(list_len - 1) : ST_EMPTY;
            CMD_DEL_POS:   st = remove_entry(int'(c.position));
            CMD_READ_OUT: begin
                if (list_len == 0) begin
                    awaited_q.push_back(make_res(ST_EMPTY, 0, 1'b1));
                end else begin
                    for (int i = 0; i < list_len; i++)
                        awaited_q.push_back(make_res(ST_OK, list_cells[i], i + 1 == list_len));
                end
                return;
            end
            default: ;
        endcase
        awaited_q.push_back(make_res(st, 0, 1'b1));
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    // predict on accepted commands, compare accepted results
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            list_len = 0;
            awaited_q.delete();
        end else begin
            if (i_cmd_valid && i_cmd_ready) predict_list_op(i_cmd_item);
            if (i_res_valid && i_res_ready) begin
                if (awaited_q.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    e = awaited_q.pop_front();
                    if (i_res_item.status !== e.status)
                        report_mismatch($sformatf("status %0d exp %0d",
                            i_res_item.status, e.status));
                    if (i_res_item.item_value !== e.item_value)
                        report_mismatch($sformatf("item_value %0d exp %0d",
                            i_res_item.item_value, e.item_value));
                    if (i_res_item.entry_count !== e.entry_count)
                        report_mismatch($sformatf("entry_count %0d exp %0d",
                            i_res_item.entry_count, e.entry_count));
                    if (i_res_item.last !== e.last)
                        report_mismatch($sformatf("last %0b exp %0b",
                            i_res_item.last, e.last));
                end
            end
        end
    end

endmodule

// ===== tb/tb_positional_list_engine_unit.sv =====
`timescale 1ns / 1ps

module tb_positional_list_engine_unit;
    import ple_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   list_size;
    int   burst_left;
    int   sent_total;

    ple_cmd_if cmd_ch();
    ple_res_if res_ch();

    positional_list_engine_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch.sink),
        .o_res  (res_ch.source)
    );

    ple_list_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_ch.valid),
        .i_cmd_ready (cmd_ch.ready),
        .i_cmd_item  (cmd_ch.payload),
        .i_res_valid (res_ch.valid),
        .i_res_ready (res_ch.ready),
        .i_res_item  (res_ch.payload),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // receiver stall pattern with calm stretches
    int stall_mode;
    initial res_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
            default: res_ch.ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    // send one command, with bursts and gaps between items
    task automatic send_cmd(t_cmd_code c, logic signed [31:0] v, logic [5:0] p);
        if (burst_left == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        cmd_ch.valid           <= 1'b1;
        cmd_ch.payload.command <= c;
        cmd_ch.payload.value   <= v;
        cmd_ch.payload.position <= p;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        burst_left--;
        sent_total++;
        // track the list size to steer the random mix
        case (c)
            CMD_APPEND, CMD_INS_FRONT:
                if (list_size < CAPACITY) list_size++;
            CMD_INS_POS:
                if (list_size < CAPACITY && (list_size == 0 || p <= list_size)) list_size++;
            CMD_DEL_FIRST, CMD_DEL_LAST:
                if (list_size > 0) list_size--;
            CMD_DEL_POS:
                if (p < list_size) list_size--;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return -1;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        t_cmd_code  c;
        logic [5:0] p;
        int         wait_cycles;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        i_rst_n        = 1'b0;
        stall_mode     = 0;
        list_size      = 0;
        burst_left     = 0;
        sent_total     = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: errors on empty list, edges and every command
        send_cmd(CMD_READ_OUT, 0, 0);
        send_cmd(CMD_DEL_FIRST, 0, 0);
        send_cmd(CMD_DEL_LAST, 0, 0);
        send_cmd(CMD_DEL_POS, 0, 0);
        send_cmd(CMD_INS_POS, 32'sh7FFFFFFF, 6'd63);
        send_cmd(CMD_INS_POS, 32'sh80000000, 6'd0);
        send_cmd(CMD_INS_POS, 5, 6'd2);
        send_cmd(CMD_INS_POS, 6, 6'd5);
        send_cmd(CMD_INS_FRONT, -1, 0);
        send_cmd(CMD_APPEND, 32'h55AA55AA, 0);
        send_cmd(CMD_INS_POS, 7, 6'd1);
        send_cmd(CMD_READ_OUT, 0, 0);
        send_cmd(CMD_DEL_POS, 0, 6'd6);
        send_cmd(CMD_DEL_POS, 0, 6'd2);
        send_cmd(CMD_DEL_LAST, 0, 0);
        send_cmd(CMD_DEL_FIRST, 0, 0);
        send_cmd(t_cmd_code'(3'd7), 32'hAAAA5555, 6'h2A);
        send_cmd(CMD_READ_OUT, 0, 0);
        // fill to capacity and probe the full case
        while (list_size < CAPACITY) send_cmd(CMD_APPEND, $urandom(), 0);
        send_cmd(CMD_APPEND, 1, 0);
        send_cmd(CMD_INS_FRONT, 2, 0);
        send_cmd(CMD_INS_POS, 3, 6'd32);
        send_cmd(CMD_READ_OUT, 0, 0);
        send_cmd(CMD_DEL_POS, 0, 6'd31);

        // random: weighted toward valid positions, sizes roam empty to full
        repeat (110) begin
            c = t_cmd_code'($urandom_range(0, 7));
            if ($urandom_range(0, 4) == 0)
                p = 6'($urandom_range(0, 63));
            else
                p = 6'($urandom_range(0, list_size));
            if (c == CMD_READ_OUT && $urandom_range(0, 2) != 0)
                c = CMD_APPEND;
            send_cmd(c, rand_value(), p);
        end
        cmd_ch.valid <= 1'b0;

        // drain
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
